// ----- sv/hphc_pkg.sv -----
// Shared base codes and divide-by-constant tables for the Halton point hit counter.
`default_nettype none

package hphc_pkg;

    typedef enum logic [1:0] {
        BASE_2,
        BASE_3,
        BASE_5
    } t_base;

    localparam int unsigned RECIP_W = 32;
    localparam int unsigned SHIFT_W = 6;
    localparam int unsigned RADIX_W = 3;
    localparam int unsigned OUT_W   = 32;

    function automatic logic [RADIX_W-1:0] base_value(input t_base b);
        logic [RADIX_W-1:0] v;
        unique case (b)
            BASE_2:  v = RADIX_W'(2);
            BASE_3:  v = RADIX_W'(3);
            BASE_5:  v = RADIX_W'(5);
            default: v = RADIX_W'(2);
        endcase
        return v;
    endfunction

    // floor(n / b) == (n * recip) >> shift for every 32-bit n
    function automatic logic [RECIP_W-1:0] base_recip(input t_base b);
        logic [RECIP_W-1:0] v;
        unique case (b)
            BASE_2:  v = 32'h8000_0000;
            BASE_3:  v = 32'hAAAA_AAAB;
            BASE_5:  v = 32'hCCCC_CCCD;
            default: v = 32'h8000_0000;
        endcase
        return v;
    endfunction

    function automatic logic [SHIFT_W-1:0] base_shift(input t_base b);
        logic [SHIFT_W-1:0] v;
        unique case (b)
            BASE_2:  v = SHIFT_W'(32);
            BASE_3:  v = SHIFT_W'(33);
            BASE_5:  v = SHIFT_W'(34);
            default: v = SHIFT_W'(32);
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- sv/halton_point_l1_hit_counter_core.sv -----
// Halton point generator in bases 2, 3 and 5 with saturating octahedron hit counter.
//
//   channel  direction  valid        stall        payload
//   input    in         i_in_valid   o_in_stall   i_point_index, i_first_point, i_last_point
//   output   out        o_out_valid  i_out_stall  o_coord_base2/3/5, o_inside_res,
//                                                 o_inside_count, o_run_done
//
// A transaction runs through the states in order: digit extraction in each base, a divide
// per coordinate, then finish; the next transaction can be accepted in the cycle after the
// result loads, so only one transaction is in flight at a time.
// Digits come from one reciprocal multiplier a cycle; each coordinate then takes FRAC_BITS
// steps of one shared restoring divider. Input stall is high from acceptance until the
// result moves into the output register, which holds while the output is stalled.
// Synchronous reset clears the sequencer, the output valid and the hit count.
`default_nettype none

module halton_point_l1_hit_counter_core #(
    parameter int unsigned INDEX_BITS = 32,
    parameter int unsigned FRAC_BITS  = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [31:0] i_point_index,
    input  wire logic        i_first_point,
    input  wire logic        i_last_point,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_coord_base2,
    output logic [31:0]      o_coord_base3,
    output logic [31:0]      o_coord_base5,
    output logic             o_inside_res,
    output logic [31:0]      o_inside_count,
    output logic             o_run_done
);
    import hphc_pkg::*;

    localparam int unsigned SCALE_W = INDEX_BITS + 3;
    localparam int unsigned PROD_W  = INDEX_BITS + RECIP_W;
    localparam int unsigned CNT_W   = $clog2(FRAC_BITS);
    localparam int unsigned SUM_W   = FRAC_BITS + 2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIGIT,
        S_DIVIDE,
        S_FINISH
    } t_state;

    t_state                r_state;
    t_base                 r_base;
    logic [INDEX_BITS-1:0] r_index;
    logic [INDEX_BITS-1:0] r_idx;
    logic [SCALE_W-1:0]    r_rev;
    logic [SCALE_W-1:0]    r_scale;
    logic [SCALE_W-1:0]    r_rem;
    logic [FRAC_BITS-1:0]  r_quot;
    logic [CNT_W-1:0]      r_cnt;
    logic [FRAC_BITS-1:0]  r_x;
    logic [FRAC_BITS-1:0]  r_y;
    logic [FRAC_BITS-1:0]  r_z;
    logic                  r_first;
    logic                  r_last;
    logic [31:0]           r_hit_total;

    logic [RADIX_W-1:0]    w_radix;
    logic [PROD_W-1:0]     w_prod;
    logic [INDEX_BITS-1:0] n_idx;
    logic [INDEX_BITS-1:0] w_diff;
    logic [RADIX_W-1:0]    w_digit;
    logic [SCALE_W-1:0]    n_rev;
    logic [SCALE_W-1:0]    n_scale;
    logic [SCALE_W:0]      w_shift;
    logic                  w_ge;
    logic [SCALE_W:0]      w_sub;
    logic [SCALE_W-1:0]    n_rem;
    logic [FRAC_BITS-1:0]  n_quot;
    logic [SUM_W-1:0]      w_sum;
    logic                  w_inside;
    logic [31:0]           w_count_base;
    logic [31:0]           n_hit_total;
    logic [31:0]           w_q2;
    logic [31:0]           w_q3;
    logic [31:0]           w_q5;
    logic                  w_load_out;

    always_comb begin
        w_radix = base_value(r_base);
        w_prod  = PROD_W'(r_idx) * PROD_W'(base_recip(r_base));
        n_idx   = INDEX_BITS'(w_prod >> base_shift(r_base));
        w_diff  = r_idx - INDEX_BITS'(n_idx * INDEX_BITS'(w_radix));
        w_digit = w_diff[RADIX_W-1:0];
        n_rev   = SCALE_W'(r_rev * SCALE_W'(w_radix)) + SCALE_W'(w_digit);
        n_scale = SCALE_W'(r_scale * SCALE_W'(w_radix));
    end

    always_comb begin
        w_shift = {r_rem, 1'b0};
        w_ge    = w_shift >= {1'b0, r_scale};
        w_sub   = w_shift - {1'b0, r_scale};
        n_rem   = w_ge ? w_sub[SCALE_W-1:0] : w_shift[SCALE_W-1:0];
        n_quot  = {r_quot[FRAC_BITS-2:0], w_ge};
    end

    always_comb begin
        w_sum        = SUM_W'(r_x) + SUM_W'(r_y) + SUM_W'(r_z);
        w_inside     = w_sum <= (SUM_W'(1) << FRAC_BITS);
        w_count_base = r_first ? 32'd0 : r_hit_total;
        n_hit_total  = (w_inside && (w_count_base != 32'hFFFF_FFFF)) ?
                       w_count_base + 32'd1 : w_count_base;
        w_load_out   = (r_state == S_FINISH) && (!o_out_valid || !i_out_stall);
    end

    generate
        if (FRAC_BITS >= OUT_W) begin : g_trunc
            assign w_q2 = r_x[FRAC_BITS-1 -: OUT_W];
            assign w_q3 = r_y[FRAC_BITS-1 -: OUT_W];
            assign w_q5 = r_z[FRAC_BITS-1 -: OUT_W];
        end else begin : g_pad
            assign w_q2 = {r_x, {(OUT_W-FRAC_BITS){1'b0}}};
            assign w_q3 = {r_y, {(OUT_W-FRAC_BITS){1'b0}}};
            assign w_q5 = {r_z, {(OUT_W-FRAC_BITS){1'b0}}};
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= BASE_2;
            r_hit_total <= 32'd0;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall && !w_load_out) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_index <= i_point_index[INDEX_BITS-1:0];
                        r_idx   <= i_point_index[INDEX_BITS-1:0];
                        r_rev   <= '0;
                        r_scale <= SCALE_W'(1);
                        r_first <= i_first_point;
                        r_last  <= i_last_point;
                        r_base  <= BASE_2;
                        r_state <= S_DIGIT;
                    end
                end
                S_DIGIT: begin
                    if (r_idx == '0) begin
                        r_rem   <= r_rev;
                        r_cnt   <= '0;
                        r_state <= S_DIVIDE;
                    end else begin
                        r_idx   <= n_idx;
                        r_rev   <= n_rev;
                        r_scale <= n_scale;
                    end
                end
                S_DIVIDE: begin
                    r_rem  <= n_rem;
                    r_quot <= n_quot;
                    r_cnt  <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(FRAC_BITS - 1)) begin
                        unique case (r_base)
                            BASE_2:  r_x <= n_quot;
                            BASE_3:  r_y <= n_quot;
                            BASE_5:  r_z <= n_quot;
                            default: r_x <= n_quot;
                        endcase
                        r_idx   <= r_index;
                        r_rev   <= '0;
                        r_scale <= SCALE_W'(1);
                        unique case (r_base)
                            BASE_2: begin
                                r_base  <= BASE_3;
                                r_state <= S_DIGIT;
                            end
                            BASE_3: begin
                                r_base  <= BASE_5;
                                r_state <= S_DIGIT;
                            end
                            default: begin
                                r_base  <= BASE_2;
                                r_state <= S_FINISH;
                            end
                        endcase
                    end
                end
                S_FINISH: begin
                    if (w_load_out) begin
                        o_coord_base2  <= w_q2;
                        o_coord_base3  <= w_q3;
                        o_coord_base5  <= w_q5;
                        o_inside_res   <= w_inside;
                        o_inside_count <= n_hit_total;
                        o_run_done     <= r_last;
                        r_hit_total    <= n_hit_total;
                        o_out_valid    <= 1'b1;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepting a transaction");

    a_rev_below_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIGIT) |-> (r_rev < r_scale))
        else $error("reversed digits reached the scale");

    a_rem_below_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVIDE) |-> (r_rem < r_scale))
        else $error("divider remainder not below the divisor");

    a_count_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |=> (o_out_valid && (!o_inside_res || (o_inside_count != 32'd0))))
        else $error("inside point left a zero count");

endmodule

`default_nettype wire
